/* design/spg_pkg.sv */
// Package: constants, state and status codes for the segmented prime gap finder.
package spg_pkg;

    localparam int SPAN       = 1048576;
    localparam int BASE_LIMIT = 46500;
    localparam int BASE_COUNT = 4800;

    localparam int SEG_AW = $clog2(SPAN);
    localparam int BASE_AW = $clog2(BASE_LIMIT);
    localparam int TAB_AW = $clog2(BASE_COUNT);
    localparam int CNT_W = $clog2(BASE_COUNT + 1);
    localparam int OFF_W = SEG_AW + 2;
    localparam int GAP_W = SEG_AW + 1;
    localparam int VAL_W = 31;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_BAD  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_BCLR,
        S_BRD,
        S_BCHK,
        S_BSTRK,
        S_IDLE,
        S_SCLR,
        S_PRD,
        S_PWAIT,
        S_PSQ,
        S_DIV,
        S_START,
        S_STRK,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* design/spg_in_if.sv */
// Query channel: valid/ready with low and high bounds.
interface spg_in_if;
    import spg_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] low_bound;
    logic [VAL_W-1:0] high_bound;

    modport source (output valid, low_bound, high_bound, input ready);
    modport sink (input valid, low_bound, high_bound, output ready);
endinterface

/* design/spg_out_if.sv */
// Result channel: valid/ready with status and the two prime pairs.
interface spg_out_if;
    import spg_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [VAL_W-1:0] closest_first;
    logic [VAL_W-1:0] closest_second;
    logic [VAL_W-1:0] farthest_first;
    logic [VAL_W-1:0] farthest_second;

    modport source (output valid, status, closest_first, closest_second,
                    farthest_first, farthest_second, input ready);
    modport sink (input valid, status, closest_first, closest_second,
                  farthest_first, farthest_second, output ready);
endinterface

/* design/segmented_prime_gap_finder.sv */
// Top level: segmented sieve that reports the closest and farthest adjacent primes of a range.
//
// Channels: i_in takes one query (low_bound, high_bound) per transfer; o_out
// gives exactly one result per query. Both are valid/ready.
// After reset the block clears its base bitmap and sieves the base primes
// below 46500, with a read and a check state per number and a strike state
// per struck multiple; i_in.ready stays low until that is done.
// A query clears the segment bitmap, then for each base prime p with
// p*p <= high reads p, squares it, takes the remainder of low by p bit by
// bit and strikes its multiples, and at last scans the segment. The segment
// bitmap memory is accessed one bit per cycle, so a full 2^20 span near the
// top of the bound range is the longest case.
// Invalid or too-wide ranges skip the sieve and go straight to the finish.
// One query is worked on at a time; i_in.ready is high only while idle.
// The result sits in an output register; a new query is taken while it
// waits, and the block holds at its finish until o_out.ready frees the
// register. Reset is synchronous and active low.
module segmented_prime_gap_finder
    import spg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    spg_in_if.sink    i_in,
    spg_out_if.source o_out
);

    t_state r_state, n_state;

    logic [BASE_AW-1:0] r_n, n_n;
    logic [BASE_AW:0]   r_m, n_m;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [VAL_W-1:0]   r_low, n_low;
    logic [VAL_W-1:0]   r_high, n_high;
    logic [SEG_AW-1:0]  r_span, n_span;
    logic [15:0]        r_p, n_p;
    logic [31:0]        r_psq, n_psq;
    logic [16:0]        r_rem, n_rem;
    logic [4:0]         r_dcnt, n_dcnt;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [SEG_AW:0]    r_scan, n_scan;
    logic               r_rd_vld, n_rd_vld;
    logic [SEG_AW-1:0]  r_rd_idx, n_rd_idx;
    logic [1:0]         r_found, n_found;
    logic               r_bad, n_bad;
    logic [VAL_W-1:0]   r_prev, n_prev;
    logic [GAP_W-1:0]   r_min, n_min;
    logic [GAP_W-1:0]   r_max, n_max;
    logic [VAL_W-1:0]   r_c1, n_c1, r_c2, n_c2, r_d1, n_d1, r_d2, n_d2;

    logic               r_out_vld, n_out_vld;
    t_status            r_out_stat, n_out_stat;
    logic [VAL_W-1:0]   r_oc1, n_oc1, r_oc2, n_oc2, r_od1, n_od1, r_od2, n_od2;

    // memories
    logic               r_bmem [BASE_LIMIT];
    logic [15:0]        r_tmem [BASE_COUNT];
    logic               r_smem [SPAN];
    logic               r_bq;
    logic [15:0]        r_tq;
    logic               r_sq;

    logic               bw_en, bw_dat;
    logic [BASE_AW-1:0] bw_addr, br_addr;
    logic               tw_en;
    logic               sw_en, sw_dat;
    logic [SEG_AW-1:0]  sw_addr, sr_addr;

    logic [31:0]        nsq;
    logic [16:0]        rem_sh;
    logic [31:0]        start;
    logic [VAL_W-1:0]   cur;
    logic [VAL_W-1:0]   diff;
    logic [GAP_W-1:0]   gap;
    logic               bad;

    always_ff @(posedge i_clk) begin
        if (bw_en) begin
            r_bmem[bw_addr] <= bw_dat;
        end
        r_bq <= r_bmem[br_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            r_tmem[r_cnt[TAB_AW-1:0]] <= r_n;
        end
        r_tq <= r_tmem[r_idx[TAB_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) begin
            r_smem[sw_addr] <= sw_dat;
        end
        r_sq <= r_smem[sr_addr];
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_vld;
    assign o_out.status          = r_out_stat;
    assign o_out.closest_first   = r_oc1;
    assign o_out.closest_second  = r_oc2;
    assign o_out.farthest_first  = r_od1;
    assign o_out.farthest_second = r_od2;

    always_comb begin
        n_state = r_state;
        n_n = r_n;       n_m = r_m;       n_cnt = r_cnt;   n_idx = r_idx;
        n_low = r_low;   n_high = r_high; n_span = r_span; n_p = r_p;
        n_psq = r_psq;   n_rem = r_rem;   n_dcnt = r_dcnt; n_off = r_off;
        n_scan = r_scan; n_rd_vld = r_rd_vld; n_rd_idx = r_rd_idx;
        n_found = r_found; n_bad = r_bad; n_prev = r_prev;
        n_min = r_min;   n_max = r_max;
        n_c1 = r_c1; n_c2 = r_c2; n_d1 = r_d1; n_d2 = r_d2;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out_stat = r_out_stat;
        n_oc1 = r_oc1; n_oc2 = r_oc2; n_od1 = r_od1; n_od2 = r_od2;

        bw_en = 1'b0; bw_dat = 1'b0; bw_addr = r_n; br_addr = r_n;
        tw_en = 1'b0;
        sw_en = 1'b0; sw_dat = 1'b0; sw_addr = r_off[SEG_AW-1:0];
        sr_addr = r_scan[SEG_AW-1:0];

        nsq    = 32'(r_n) * 32'(r_n);
        rem_sh = {r_rem[15:0], r_low[r_dcnt]};
        start  = (r_rem == 17'd0) ? {1'b0, r_low}
                 : {1'b0, r_low} - 32'(r_rem) + 32'(r_p);
        if (start == 32'(r_p)) begin
            start = start + 32'(r_p);
        end
        cur  = r_low + VAL_W'(r_rd_idx);
        diff = cur - r_prev;
        gap  = diff[GAP_W-1:0];
        bad  = (i_in.low_bound == '0) || (i_in.low_bound > i_in.high_bound)
               || ((i_in.high_bound - i_in.low_bound) >= VAL_W'(SPAN));

        case (r_state)
            S_BCLR: begin
                bw_en  = 1'b1;
                bw_dat = (r_n >= BASE_AW'(2));
                if (r_n == BASE_AW'(BASE_LIMIT - 1)) begin
                    n_n = BASE_AW'(2);
                    n_state = S_BRD;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end
            S_BRD: begin
                n_state = S_BCHK;
            end
            S_BCHK: begin
                if (r_bq) begin
                    if (r_cnt < CNT_W'(BASE_COUNT)) begin
                        tw_en = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (r_bq && nsq < 32'(BASE_LIMIT)) begin
                    n_m = nsq[BASE_AW:0];
                    n_state = S_BSTRK;
                end else if (r_n == BASE_AW'(BASE_LIMIT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_n = r_n + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_BSTRK: begin
                bw_addr = r_m[BASE_AW-1:0];
                if (r_m < (BASE_AW + 1)'(BASE_LIMIT)) begin
                    bw_en = 1'b1;
                    n_m = r_m + (BASE_AW + 1)'(r_n);
                end else if (r_n == BASE_AW'(BASE_LIMIT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_n = r_n + 1'b1;
                    n_state = S_BRD;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_low   = i_in.low_bound;
                    n_high  = i_in.high_bound;
                    n_span  = SEG_AW'(i_in.high_bound - i_in.low_bound);
                    n_bad   = bad;
                    n_found = 2'd0;
                    n_off   = '0;
                    n_c1 = '0; n_c2 = '0; n_d1 = '0; n_d2 = '0;
                    n_state = bad ? S_DONE : S_SCLR;
                end
            end
            S_SCLR: begin
                sw_en  = 1'b1;
                // 1 is not prime
                sw_dat = !(r_off == '0 && r_low == VAL_W'(1));
                if (r_off == OFF_W'(r_span)) begin
                    n_idx = '0;
                    n_state = S_PRD;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            S_PRD: begin
                if (r_idx == r_cnt) begin
                    n_scan = '0;
                    n_rd_vld = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_PWAIT;
                end
            end
            S_PWAIT: begin
                n_p   = r_tq;
                n_psq = 32'(r_tq) * 32'(r_tq);
                n_state = S_PSQ;
            end
            S_PSQ: begin
                if (r_psq > 32'(r_high)) begin
                    n_scan = '0;
                    n_rd_vld = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_rem  = '0;
                    n_dcnt = 5'(VAL_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle, remainder only
                n_rem = (rem_sh >= {1'b0, r_p}) ? rem_sh - {1'b0, r_p} : rem_sh;
                if (r_dcnt == '0) begin
                    n_state = S_START;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                end
            end
            S_START: begin
                n_off = OFF_W'(start - {1'b0, r_low});
                n_state = S_STRK;
            end
            S_STRK: begin
                if (r_off <= OFF_W'(r_span)) begin
                    sw_en = 1'b1;
                    n_off = r_off + OFF_W'(r_p);
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_PRD;
                end
            end
            S_SCAN: begin
                if (r_scan <= (SEG_AW + 1)'(r_span)) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan[SEG_AW-1:0];
                    n_scan   = r_scan + 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        n_state = S_DONE;
                    end
                end
                if (r_rd_vld && r_sq) begin
                    n_prev = cur;
                    if (r_found == 2'd0) begin
                        n_found = 2'd1;
                    end else begin
                        if (r_found == 2'd1 || gap < r_min) begin
                            n_min = gap; n_c1 = r_prev; n_c2 = cur;
                        end
                        if (r_found == 2'd1 || gap > r_max) begin
                            n_max = gap; n_d1 = r_prev; n_d2 = cur;
                        end
                        n_found = 2'd2;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_stat = r_bad ? STAT_BAD
                                 : (r_found != 2'd2) ? STAT_FEW : STAT_OK;
                    n_oc1 = r_c1; n_oc2 = r_c2; n_od1 = r_d1; n_od2 = r_d2;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_BCLR;
            r_n       <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_n       <= n_n;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;       r_idx <= n_idx;   r_low <= n_low;   r_high <= n_high;
        r_span <= n_span; r_p <= n_p;       r_psq <= n_psq;   r_rem <= n_rem;
        r_dcnt <= n_dcnt; r_off <= n_off;   r_scan <= n_scan; r_rd_idx <= n_rd_idx;
        r_found <= n_found; r_bad <= n_bad; r_prev <= n_prev;
        r_min <= n_min;   r_max <= n_max;
        r_c1 <= n_c1; r_c2 <= n_c2; r_d1 <= n_d1; r_d2 <= n_d2;
        r_out_stat <= n_out_stat;
        r_oc1 <= n_oc1; r_oc2 <= n_oc2; r_od1 <= n_od1; r_od2 <= n_od2;
    end

endmodule

/* design/spg_checker.sv */
// Port checker for the segmented prime gap finder, bound to the top level.
module spg_checker
    import spg_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_status,
    input logic [VAL_W-1:0] i_c1,
    input logic [VAL_W-1:0] i_c2,
    input logic [VAL_W-1:0] i_d1,
    input logic [VAL_W-1:0] i_d2
);

    // a held result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // one query at a time: busy right after a query transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready after query transfer");

    a_zero_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_OK |->
            i_c1 == '0 && i_c2 == '0 && i_d1 == '0 && i_d2 == '0)
        else $error("pair fields set without pairs");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STAT_OK |->
            i_c1 < i_c2 && i_d1 < i_d2 && (i_c2 - i_c1) <= (i_d2 - i_d1))
        else $error("pair order or gap relation broken");

endmodule

bind segmented_prime_gap_finder spg_checker u_spg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_c1        (o_out.closest_first),
    .i_c2        (o_out.closest_second),
    .i_d1        (o_out.farthest_first),
    .i_d2        (o_out.farthest_second)
);
